>>> design/eucd_pkg.sv
// Shared types and constants for the EUC-JP to packed code decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package eucd_pkg;

    // Lead bytes with special meaning
    localparam logic [7:0] LEAD_KANA = 8'h8E;
    localparam logic [7:0] LEAD_SUPP = 8'h8F;

    // Terminator status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_TRUNC = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [15:0] MAX_CHARS_RESET = 16'hFFFF;

    // Result queue depth; one input byte may push two results
    localparam int QDEPTH = 4;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_input;
    } t_in;

    typedef struct packed {
        logic [15:0] code;
        logic        is_terminator;
        logic [1:0]  status;
        logic [15:0] char_total;
    } t_out;

    // Up to two results written to the queue in one cycle, first one first
    typedef struct packed {
        logic push0;
        logic push1;
        t_out data0;
        t_out data1;
    } t_push;

endpackage

`default_nettype wire

>>> design/euc_to_packed_decoder.sv
// Top level of the EUC-JP to packed 16-bit code decoder.
// Depends on eucd_pkg, eucd_core and eucd_outq.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one EUC-JP byte
//   per transaction, with end_of_input set on the last byte of a string.
//   Output channel (o_out_valid / i_out_ready / o_out_data) delivers one
//   packed character code per complete character, and one terminator result
//   (status and character count) after the last byte of each string.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes max_chars;
//   it is always ready. Write it only while the block is idle.
//   Throughput: one byte per cycle while the result queue has room. A final
//   byte that also completes a character yields two results, which leave the
//   output one at a time; the four-entry result queue absorbs that.
//   The first result of a byte passes through the input register and then
//   the result queue before it shows on the output.
//   Reset: max_chars returns to 65535, decode state and queue clear.
//   Stall: while i_out_ready is low the queue fills; o_in_ready drops while a
//   byte waits in the input register and fewer than two queue entries are free.
`default_nettype none

module euc_to_packed_decoder (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire eucd_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output eucd_pkg::t_out      o_out_data,
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic [15:0]    i_cfg_data
);
    import eucd_pkg::*;

    t_push push;
    logic  room;

    assign o_cfg_ready = 1'b1;

    eucd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_room      (room),
        .o_push      (push)
    );

    eucd_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

>>> design/eucd_core.sv
// Input register, decode state and character/terminator generation.
// Depends on eucd_pkg; feeds eucd_outq through a t_push struct.
`default_nettype none

module eucd_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire eucd_pkg::t_in i_in_data,
    input  wire logic          i_cfg_valid,
    input  wire logic [15:0]   i_cfg_data,
    input  wire logic          i_room,
    output eucd_pkg::t_push    o_push
);
    import eucd_pkg::*;

    typedef enum logic [2:0] {
        PH_LEAD  = 3'd0,
        PH_KANA  = 3'd1,
        PH_SUPP1 = 3'd2,
        PH_SUPP2 = 3'd3,
        PH_KANJI = 3'd4
    } t_phase;

    logic        r_valid;
    t_in         r_in;
    logic [15:0] r_max_chars;
    t_phase      r_phase, n_phase;
    logic [6:0]  r_held, n_held;
    logic [15:0] r_count, n_count;
    logic        r_full, n_full;

    logic        advance;
    logic        have;
    logic [15:0] code;
    logic [15:0] count_inc;
    logic [6:0]  low;
    t_out        char_res;
    t_out        term_res;
    logic [1:0]  term_status;

    assign advance    = r_valid && i_room;
    assign o_in_ready = !r_valid || advance;
    assign low        = r_in.byte_in[6:0];

    always_comb begin
        have    = 1'b0;
        code    = '0;
        n_phase = r_phase;
        n_held  = r_held;
        n_full  = r_full;
        if (!r_full) begin
            unique case (r_phase)
                PH_KANA: begin
                    code    = {8'h00, 1'b1, low};
                    have    = 1'b1;
                    n_phase = PH_LEAD;
                end
                PH_SUPP1: begin
                    n_held  = low;
                    n_phase = PH_SUPP2;
                end
                PH_SUPP2: begin
                    code    = {1'b1, r_held, 1'b0, low};
                    have    = 1'b1;
                    n_phase = PH_LEAD;
                end
                PH_KANJI: begin
                    code    = {1'b1, r_held, 1'b1, low};
                    have    = 1'b1;
                    n_phase = PH_LEAD;
                end
                default: begin
                    n_phase = PH_LEAD;
                    priority if (r_count >= r_max_chars) begin
                        n_full = 1'b1;
                    end else if (!r_in.byte_in[7]) begin
                        code = {8'h00, r_in.byte_in};
                        have = 1'b1;
                    end else if (r_in.byte_in == LEAD_KANA) begin
                        n_phase = PH_KANA;
                    end else if (r_in.byte_in == LEAD_SUPP) begin
                        n_phase = PH_SUPP1;
                    end else begin
                        n_held  = low;
                        n_phase = PH_KANJI;
                    end
                end
            endcase
        end

        count_inc = r_count + 16'd1;
        n_count   = have ? count_inc : r_count;

        // Capacity overrides truncation
        priority if (n_full) begin
            term_status = ST_FULL;
        end else if (n_phase != PH_LEAD) begin
            term_status = ST_TRUNC;
        end else begin
            term_status = ST_OK;
        end

        char_res = '{code: code, is_terminator: 1'b0, status: ST_OK, char_total: n_count};
        term_res = '{code: 16'h0000, is_terminator: 1'b1, status: term_status,
                     char_total: n_count};

        o_push.push0 = advance && (have || r_in.end_of_input);
        o_push.push1 = advance && have && r_in.end_of_input;
        o_push.data0 = have ? char_res : term_res;
        o_push.data1 = term_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_max_chars <= MAX_CHARS_RESET;
            r_phase     <= PH_LEAD;
            r_held      <= '0;
            r_count     <= '0;
            r_full      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_max_chars <= i_cfg_data;
            end
            if (o_in_ready) begin
                r_valid <= i_in_valid;
            end
            if (advance) begin
                if (r_in.end_of_input) begin
                    // clear per-string state after the terminator
                    r_phase <= PH_LEAD;
                    r_held  <= '0;
                    r_count <= '0;
                    r_full  <= 1'b0;
                end else begin
                    r_phase <= n_phase;
                    r_held  <= n_held;
                    r_count <= n_count;
                    r_full  <= n_full;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

endmodule

`default_nettype wire

>>> design/eucd_outq.sv
// Result queue: takes up to two results per cycle, one out per ready cycle.
// Depends on eucd_pkg for t_out, t_push and QDEPTH.
`default_nettype none

module eucd_outq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire eucd_pkg::t_push i_push,
    output logic                 o_room,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output eucd_pkg::t_out       o_out_data
);
    import eucd_pkg::*;

    localparam int PW = $clog2(QDEPTH);
    localparam int CW = $clog2(QDEPTH + 1);

    t_out          r_mem [QDEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          pop;
    logic [PW-1:0] wr_ptr1;

    assign pop         = o_out_valid && i_out_ready;
    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_mem[r_rd_ptr];
    assign o_room      = (r_count <= CW'(QDEPTH - 2));
    assign wr_ptr1     = r_wr_ptr + PW'(1);

    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_mem[r_wr_ptr] <= i_push.data0;
        end
        if (i_push.push1) begin
            r_mem[wr_ptr1] <= i_push.data1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PW'(i_push.push0) + PW'(i_push.push1);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            r_count <= r_count + CW'(i_push.push0) + CW'(i_push.push1) - CW'(pop);
        end
    end

endmodule

`default_nettype wire

>>> design/eucd_checker.sv
// Port-level checks for euc_to_packed_decoder, bound to the top level.
// Depends on eucd_pkg for the result type and status codes.
`default_nettype none

module eucd_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           o_out_valid,
    input wire logic           i_out_ready,
    input wire eucd_pkg::t_out o_out_data
);
    import eucd_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or dropped");

    a_char_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.is_terminator |-> o_out_data.status == ST_OK)
        else $error("character result carries nonzero status");

    a_term_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.is_terminator |-> o_out_data.code == 16'h0000)
        else $error("terminator carries nonzero code");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.status == ST_OK || o_out_data.status == ST_TRUNC
                        || o_out_data.status == ST_FULL)
        else $error("undefined status code");

endmodule

bind euc_to_packed_decoder eucd_checker u_eucd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire

>>> test/tb_euc_to_packed_decoder.sv
`timescale 1ns / 100ps
// Testbench for euc_to_packed_decoder: byte streams in, packed codes and terminators out.
// Depends on eucd_pkg and the decoder RTL; predicts every result and checks it in order.

module tb_euc_to_packed_decoder;

    import eucd_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASE_ITEMS    = 80;

    typedef enum logic [2:0] {
        PH_LEAD, PH_KANA, PH_SUPP1, PH_SUPP2, PH_TRAIL
    } t_phase;

    typedef enum int {
        CH_ASCII, CH_KANA, CH_SUPP, CH_KANJI
    } t_char_kind;

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_in_valid  = 1'b0;
    t_in           i_in_data   = '0;
    logic          i_out_ready = 1'b0;
    logic          i_cfg_valid = 1'b0;
    logic [15:0]   i_cfg_data  = '0;
    logic          o_in_ready;
    logic          o_out_valid;
    t_out          o_out_data;
    logic          o_cfg_ready;

    // Decoder state as predicted
    t_phase        dec_phase = PH_LEAD;
    logic [6:0]    dec_held  = '0;
    logic [15:0]   dec_count = '0;
    logic          dec_full  = 1'b0;
    logic [15:0]   cap_limit = MAX_CHARS_RESET;

    t_out          pending_results[$];
    t_out          want;
    int            mismatches     = 0;
    int            bytes_sent     = 0;
    int            quiet_cycles   = 0;
    int            rx_hold_cycles = 0;
    int            tx_idle_pct    = 0;
    int            rx_stall_pct   = 0;

    euc_to_packed_decoder u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void predict_decode(input t_in item);
        logic [6:0]  low7;
        logic        have;
        logic [15:0] code;
        t_out        res;
        low7 = item.byte_in[6:0];
        have = 1'b0;
        code = '0;
        if (!dec_full) begin
            case (dec_phase)
                PH_KANA: begin
                    code      = {8'h00, 1'b1, low7};
                    have      = 1'b1;
                    dec_phase = PH_LEAD;
                end
                PH_SUPP1: begin
                    dec_held  = low7;
                    dec_phase = PH_SUPP2;
                end
                PH_SUPP2: begin
                    code      = {1'b1, dec_held, 1'b0, low7};
                    have      = 1'b1;
                    dec_phase = PH_LEAD;
                end
                PH_TRAIL: begin
                    code      = {1'b1, dec_held, 1'b1, low7};
                    have      = 1'b1;
                    dec_phase = PH_LEAD;
                end
                default: begin
                    dec_phase = PH_LEAD;
                    if (dec_count >= cap_limit) begin
                        dec_full = 1'b1;
                    end else if (!item.byte_in[7]) begin
                        code = {8'h00, item.byte_in};
                        have = 1'b1;
                    end else if (item.byte_in == LEAD_KANA) begin
                        dec_phase = PH_KANA;
                    end else if (item.byte_in == LEAD_SUPP) begin
                        dec_phase = PH_SUPP1;
                    end else begin
                        dec_held  = low7;
                        dec_phase = PH_TRAIL;
                    end
                end
            endcase
        end
        if (have) begin
            dec_count         = dec_count + 16'd1;
            res.code          = code;
            res.is_terminator = 1'b0;
            res.status        = ST_OK;
            res.char_total    = dec_count;
            pending_results.push_back(res);
        end
        if (item.end_of_input) begin
            res.code          = '0;
            res.is_terminator = 1'b1;
            res.status        = dec_full ? ST_FULL :
                                (dec_phase != PH_LEAD) ? ST_TRUNC : ST_OK;
            res.char_total    = dec_count;
            pending_results.push_back(res);
            dec_phase = PH_LEAD;
            dec_held  = '0;
            dec_count = '0;
            dec_full  = 1'b0;
        end
    endfunction

    function automatic logic [7:0] kanji_lead();
        logic [7:0] b;
        do b = 8'($urandom_range(8'h80, 8'hFF));
        while (b == LEAD_KANA || b == LEAD_SUPP);
        return b;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        t_in item;
        item.byte_in      = b;
        item.end_of_input = last;
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        predict_decode(item);
        bytes_sent++;
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
    endtask

    task automatic send_char(input t_char_kind kind, input logic last);
        case (kind)
            CH_ASCII: send_byte(8'($urandom_range(0, 127)), last);
            CH_KANA: begin
                send_byte(LEAD_KANA, 1'b0);
                send_byte(8'($urandom_range(0, 255)), last);
            end
            CH_SUPP: begin
                send_byte(LEAD_SUPP, 1'b0);
                send_byte(8'($urandom_range(0, 255)), 1'b0);
                send_byte(8'($urandom_range(0, 255)), last);
            end
            default: begin
                send_byte(kanji_lead(), 1'b0);
                send_byte(8'($urandom_range(0, 255)), last);
            end
        endcase
    endtask

    // With cut set, end the string in the middle of a multibyte character
    task automatic send_string(input int nchars, input bit cut);
        for (int i = 0; i < nchars; i++) begin
            send_char(t_char_kind'($urandom_range(0, 3)), !cut && i == nchars - 1);
        end
        if (cut) begin
            case ($urandom_range(0, 3))
                0: send_byte(LEAD_KANA, 1'b1);
                1: send_byte(LEAD_SUPP, 1'b1);
                2: begin
                    send_byte(LEAD_SUPP, 1'b0);
                    send_byte(8'($urandom_range(0, 255)), 1'b1);
                end
                default: send_byte(kanji_lead(), 1'b1);
            endcase
        end
    endtask

    task automatic send_noise(input int nbytes);
        for (int i = 0; i < nbytes; i++) begin
            send_byte(8'($urandom_range(0, 255)),
                      i == nbytes - 1 || $urandom_range(0, 9) == 0);
        end
    endtask

    // Drop valid, wait out every expected result, then let the pipeline settle
    task automatic wait_block_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_max_chars(input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        cap_limit = value;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_char_classes();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
        // final byte completes a character: character first, terminator second
        send_byte(LEAD_KANA, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(LEAD_SUPP, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(LEAD_SUPP, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        // truncated sequences and a one-byte ASCII string
        send_byte(LEAD_KANA, 1'b1);
        send_byte(LEAD_SUPP, 1'b0);
        send_byte(8'h41, 1'b1);
        send_byte(8'hA1, 1'b1);
        send_byte(8'h41, 1'b1);
        // trail below 0x80 and lead values as trails
        send_byte(8'hB0, 1'b0);
        send_byte(8'h20, 1'b1);
        send_byte(LEAD_KANA, 1'b0);
        send_byte(LEAD_SUPP, 1'b1);
    endtask

    task automatic test_capacity();
        wait_block_idle();
        write_max_chars(16'd2);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b0);
        send_byte(8'h43, 1'b0);
        send_byte(LEAD_KANA, 1'b1);
        // exact fit ends with status ok
        send_byte(8'h41, 1'b0);
        send_byte(8'hB0, 1'b0);
        send_byte(8'hA1, 1'b1);
        wait_block_idle();
        write_max_chars(16'd1);
        // a begun character completes, the rest is dropped
        send_byte(8'hB0, 1'b0);
        send_byte(8'hA1, 1'b0);
        send_byte(8'h42, 1'b0);
        send_byte(LEAD_SUPP, 1'b1);
        wait_block_idle();
        write_max_chars(16'd0);
        send_byte(8'h41, 1'b1);
        send_byte(LEAD_KANA, 1'b0);
        send_byte(8'h41, 1'b1);
        wait_block_idle();
        write_max_chars(MAX_CHARS_RESET);
    endtask

    task automatic test_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        // hold the output off so the result queue fills and the input stalls
        rx_hold_cycles <= 200;
        send_string(30, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hB0, 1'b0);
        wait_block_idle();
        send_byte(8'hA1, 1'b0);
        send_byte(LEAD_SUPP, 1'b0);
        wait_block_idle();
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b1);
    endtask

    task automatic test_random_mix();
        logic [15:0] caps [5];
        int          start;
        int          pick;
        caps = '{16'hFFFF, 16'd0, 16'd3, 16'($urandom_range(1, 8)), 16'($urandom)};
        for (int p = 0; p < 5; p++) begin
            wait_block_idle();
            write_max_chars(caps[p]);
            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 48; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 48; end
                default: begin tx_idle_pct = 28; rx_stall_pct = 28; end
            endcase
            start = bytes_sent;
            while (bytes_sent - start < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 78) begin
                    if ($urandom_range(0, 9) == 0) send_string($urandom_range(8, 24), 1'b0);
                    else send_string($urandom_range(1, 6), 1'b0);
                end else if (pick < 90) begin
                    send_string($urandom_range(0, 4), 1'b1);
                end else begin
                    send_noise($urandom_range(1, 8));
                end
            end
        end
    endtask

    // Receiver: random stalls, an optional long hold-off, in-order result check
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: code %h term %b status %0d total %0d",
                                 o_out_data.code, o_out_data.is_terminator,
                                 o_out_data.status, o_out_data.char_total);
                end else begin
                    want = pending_results.pop_front();
                    if (o_out_data.code !== want.code
                            || o_out_data.is_terminator !== want.is_terminator
                            || o_out_data.status !== want.status
                            || o_out_data.char_total !== want.char_total) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result mismatch: expected code %h term %b status %0d",
                                      " total %0d, got code %h term %b status %0d total %0d"},
                                     want.code, want.is_terminator, want.status,
                                     want.char_total, o_out_data.code,
                                     o_out_data.is_terminator, o_out_data.status,
                                     o_out_data.char_total);
                    end
                end
            end
            if (rx_hold_cycles > 0) begin
                rx_hold_cycles <= rx_hold_cycles - 1;
                i_out_ready    <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                    || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("euc_to_packed_decoder: mismatch");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_char_classes();
        test_capacity();
        test_backpressure();
        test_random_mix();
        wait_block_idle();
        repeat (2 * DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("euc_to_packed_decoder: match");
        end else begin
            $display("euc_to_packed_decoder: mismatch");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/eucd_pkg.sv
design/eucd_core.sv
design/eucd_outq.sv
design/euc_to_packed_decoder.sv
design/eucd_checker.sv
test/tb_euc_to_packed_decoder.sv
